@@ sv/ght_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg
// Shared widths, command codes and the result record of the handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int SLOTS_PER_KIND   = 256;
    localparam int KIND_COUNT       = 7;
    localparam int HANDLE_GEN_SHIFT = 24;

    localparam int CMD_W    = 2;
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 8;
    localparam int KEY_W    = 64;
    localparam int NCNT_W   = 9;
    localparam int GEN_W    = 8;
    localparam int HANDLE_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_COMMIT = 2'd2
    } t_cmd;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   slot_out;
        logic [GEN_W-1:0]    generation;
        logic [HANDLE_W-1:0] handle;
        logic                bumped;
    } t_rsp;

endpackage
`default_nettype wire

@@ sv/ght_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_cmd_if / ght_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ght_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [ght_pkg::CMD_W-1:0]   command;
    logic [ght_pkg::KIND_W-1:0]  kind;
    logic [ght_pkg::SLOT_W-1:0]  slot_index;
    logic [ght_pkg::KEY_W-1:0]   key_id;
    logic [ght_pkg::NCNT_W-1:0]  new_count;

    modport source (output valid, command, kind, slot_index, key_id, new_count,
                    input ready);
    modport sink   (input valid, command, kind, slot_index, key_id, new_count,
                    output ready);
endinterface

interface ght_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [ght_pkg::SLOT_W-1:0]    slot_out;
    logic [ght_pkg::GEN_W-1:0]     generation;
    logic [ght_pkg::HANDLE_W-1:0]  handle;
    logic                          bumped;

    modport source (output valid, found, slot_out, generation, handle, bumped,
                    input ready);
    modport sink   (input valid, found, slot_out, generation, handle, bumped,
                    output ready);
endinterface
`default_nettype wire

@@ sv/ght_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_out_reg
// Single-entry output register for result items.
// ----------------------------------------------------------------------------
module ght_out_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire ght_pkg::t_rsp i_data,
    output logic               o_ready,
    ght_rsp_if.source          o_rsp
);
    import ght_pkg::*;

    logic r_valid;
    t_rsp r_data;

    assign o_ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.found      = r_data.found;
    assign o_rsp.slot_out   = r_data.slot_out;
    assign o_rsp.generation = r_data.generation;
    assign o_rsp.handle     = r_data.handle;
    assign o_rsp.bumped     = r_data.bumped;

endmodule
`default_nettype wire

@@ sv/generational_handle_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Generational handle table. One command item is worked at a time. A find
// reads the kind's id and generation memories one slot per cycle; a write
// reads the slot, compares the ids and writes back. After reset a clearing
// pass zeroes the generation memory, one entry per cycle, before the first item
// is taken. A result waits in an output register so its consumer may stall.
// ----------------------------------------------------------------------------
// generational_handle_table
// Per-kind slot table of ids with generation counters and handle lookup.
// ----------------------------------------------------------------------------
module generational_handle_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ght_cmd_if.sink    i_cmd,
    ght_rsp_if.source  o_rsp
);
    import ght_pkg::*;

    localparam int DEPTH      = KIND_COUNT * SLOTS_PER_KIND;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_IDX_W = (SLOTS_PER_KIND > 1) ? $clog2(SLOTS_PER_KIND) : 1;
    localparam int KIND_IDX_W = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOTS_PER_KIND + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_WRITE,
        S_EMIT
    } t_state;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [KIND_W-1:0] kind,
                                                    input logic [SLOT_IDX_W-1:0] slot);
        return ADDR_W'(ADDR_W'(kind) * ADDR_W'(SLOTS_PER_KIND)) + ADDR_W'(slot);
    endfunction

    t_state                r_state;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [CMD_W-1:0]      r_cmd;
    logic [KIND_W-1:0]     r_kind;
    logic [SLOT_W-1:0]     r_slot;
    logic [KEY_W-1:0]      r_key;
    logic [NCNT_W-1:0]     r_new_count;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_next;
    logic                  r_pend;
    logic [SLOT_IDX_W-1:0] r_pend_slot;
    logic [CNT_W-1:0]      r_live [KIND_COUNT];
    t_rsp                  r_res;

    logic [KEY_W-1:0]      id_mem  [DEPTH];
    logic [GEN_W-1:0]      gen_mem [DEPTH];
    logic [KEY_W-1:0]      r_id_rd;
    logic [GEN_W-1:0]      r_gen_rd;

    logic                  kind_ok;
    logic                  slot_ok;
    logic [KIND_IDX_W-1:0] kind_idx;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  id_we;
    logic                  gen_we;
    logic [ADDR_W-1:0]     gen_addr;
    logic [GEN_W-1:0]      gen_wdata;
    logic                  bump;
    logic                  hit;
    logic                  out_ready;
    logic                  push;
    logic [CNT_W-1:0]      sat_count;
    t_rsp                  no_result;

    assign kind_ok  = int'(r_kind) < KIND_COUNT;
    assign slot_ok  = int'(r_slot) < SLOTS_PER_KIND;
    assign kind_idx = r_kind[KIND_IDX_W-1:0];
    assign wr_addr  = slot_addr(r_kind, SLOT_IDX_W'(r_slot));
    assign rd_addr  = (r_state == S_DECODE) ? wr_addr
                                            : slot_addr(r_kind, r_next[SLOT_IDX_W-1:0]);

    assign bump = (CNT_W'(r_slot) < r_count) && (r_id_rd != r_key);
    assign hit  = r_pend && (r_id_rd == r_key);

    assign id_we     = (r_state == S_WRITE);
    assign gen_we    = (r_state == S_CLEAR) || ((r_state == S_WRITE) && bump);
    assign gen_addr  = (r_state == S_CLEAR) ? r_clr_addr : wr_addr;
    assign gen_wdata = (r_state == S_CLEAR) ? '0 : r_gen_rd + GEN_W'(1);

    assign sat_count = (int'(r_new_count) > SLOTS_PER_KIND) ? CNT_W'(SLOTS_PER_KIND)
                                                            : CNT_W'(r_new_count);

    assign no_result = '{found: 1'b0, slot_out: '0, generation: '0,
                         handle: '1, bumped: 1'b0};

    assign i_cmd.ready = (r_state == S_IDLE);
    assign push        = (r_state == S_EMIT);

    // Memories: registered read, one write port each
    always_ff @(posedge i_clk) begin
        r_id_rd  <= id_mem[rd_addr];
        r_gen_rd <= gen_mem[rd_addr];
        if (id_we) begin
            id_mem[wr_addr] <= r_key;
        end
        if (gen_we) begin
            gen_mem[gen_addr] <= gen_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
            for (int k = 0; k < KIND_COUNT; k++) begin
                r_live[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd       <= i_cmd.command;
                        r_kind      <= i_cmd.kind;
                        r_slot      <= i_cmd.slot_index;
                        r_key       <= i_cmd.key_id;
                        r_new_count <= i_cmd.new_count;
                        r_state     <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_res  <= no_result;
                    r_next <= '0;
                    r_pend <= 1'b0;
                    priority if (r_cmd == CMD_FIND && kind_ok) begin
                        r_count <= r_live[kind_idx];
                        r_state <= S_FIND;
                    end else if (r_cmd == CMD_WRITE && kind_ok && slot_ok) begin
                        // id/generation read of the slot is in flight
                        r_count <= r_live[kind_idx];
                        r_state <= S_WRITE;
                    end else if (r_cmd == CMD_COMMIT && kind_ok) begin
                        r_live[kind_idx] <= sat_count;
                        r_state          <= S_EMIT;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_FIND: begin
                    priority if (hit) begin
                        r_res.found      <= 1'b1;
                        r_res.slot_out   <= SLOT_W'(r_pend_slot);
                        r_res.generation <= r_gen_rd;
                        r_res.handle     <= HANDLE_W'(r_pend_slot)
                                          | (HANDLE_W'(r_gen_rd) << HANDLE_GEN_SHIFT);
                        r_pend           <= 1'b0;
                        r_state          <= S_EMIT;
                    end else if (r_next < r_count) begin
                        // advance the scan: data for this slot lands next cycle
                        r_pend      <= 1'b1;
                        r_pend_slot <= r_next[SLOT_IDX_W-1:0];
                        r_next      <= r_next + CNT_W'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_WRITE: begin
                    r_res.generation <= bump ? gen_wdata : r_gen_rd;
                    r_res.bumped     <= bump;
                    r_state          <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    ght_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push),
        .i_data  (r_res),
        .o_ready (out_ready),
        .o_rsp   (o_rsp)
    );

    // No item is taken while generations are being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_cmd.ready)
        else $error("item accepted during clearing pass");

    // One item at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("second item accepted while one is in flight");

    // A scan never writes the memories
    a_find_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> (!id_we && !gen_we))
        else $error("memory write during find scan");

    // Every result that is not a hit carries the null handle
    a_null_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.handle == '1))
        else $error("miss result without null handle");

endmodule
`default_nettype wire

@@ verif/generational_handle_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table_tb
// Drives find, write and commit items into the handle table. An in-bench
// slot map tracks ids, generations and live counts and checks every result in
// order. The run uses idle and stall patterns, a long result back-pressure
// stretch and a generation wrap. Slots are only committed live once written.
// ----------------------------------------------------------------------------
module generational_handle_table_tb;
    import ght_pkg::*;

    localparam int unsigned TOTAL_ITEMS = 1150;
    localparam int unsigned MAX_SHOWN   = 10;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned SETTLE      = 300;
    localparam int unsigned FULL_KIND   = 3;
    localparam int unsigned WRAP_KIND   = 0;
    localparam int unsigned WRAP_WRITES = 260;

    localparam logic [CMD_W-1:0]    CMD_UNUSED = 2'd3;
    localparam logic [KIND_W-1:0]   KIND_NONE  = 3'd7;
    localparam logic [HANDLE_W-1:0] NO_HANDLE  = '1;
    localparam logic [KEY_W-1:0]    KEY_ONES   = '1;
    localparam logic [KEY_W-1:0]    KEY_MSB    = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [NCNT_W-1:0] count;
    } t_cmd_item;

    // Slot map mirror: predicts one result per command and checks them in order.
    class slot_map_scoreboard;
        logic [KEY_W-1:0]  id_mem  [KIND_COUNT][SLOTS_PER_KIND];
        logic [GEN_W-1:0]  gen_mem [KIND_COUNT][SLOTS_PER_KIND];
        bit                written [KIND_COUNT][SLOTS_PER_KIND];
        int unsigned       live    [KIND_COUNT];
        t_rsp              pending_rsp[$];
        int unsigned       mismatches, checked;
        int unsigned       finds, hits, writes, bumps, wraps, commits, ignored;

        function new();
            for (int k = 0; k < KIND_COUNT; k++) begin
                live[k] = 0;
                for (int s = 0; s < SLOTS_PER_KIND; s++) begin
                    id_mem[k][s]  = '0;
                    gen_mem[k][s] = '0;
                    written[k][s] = 0;
                end
            end
        endfunction

        function int unsigned first_unwritten(int unsigned k);
            for (int unsigned s = 0; s < SLOTS_PER_KIND; s++)
                if (!written[k][s]) return s;
            return SLOTS_PER_KIND;
        endfunction

        function void note_command(t_cmd_item c);
            t_rsp        r;
            int unsigned k, s, i;
            bit          hit;
            r.found      = 1'b0;
            r.slot_out   = '0;
            r.generation = '0;
            r.handle     = NO_HANDLE;
            r.bumped     = 1'b0;
            k = c.kind;
            s = c.slot;
            if (k < KIND_COUNT && c.command == CMD_FIND) begin
                finds++;
                hit = 0;
                for (i = 0; i < live[k] && !hit; i++) begin
                    if (id_mem[k][i] == c.key) begin
                        hit          = 1;
                        r.found      = 1'b1;
                        r.slot_out   = SLOT_W'(i);
                        r.generation = gen_mem[k][i];
                        r.handle     = {gen_mem[k][i], 24'(i)};
                    end
                end
                if (hit) hits++;
            end else if (k < KIND_COUNT && c.command == CMD_WRITE) begin
                writes++;
                // bump only a live slot whose id really changes
                if (s < live[k] && id_mem[k][s] != c.key) begin
                    gen_mem[k][s] = gen_mem[k][s] + 1'b1;
                    r.bumped      = 1'b1;
                    bumps++;
                    if (gen_mem[k][s] == '0) wraps++;
                end
                id_mem[k][s]  = c.key;
                written[k][s] = 1;
                r.generation  = gen_mem[k][s];
            end else if (k < KIND_COUNT && c.command == CMD_COMMIT) begin
                commits++;
                live[k] = (c.count > SLOTS_PER_KIND) ? SLOTS_PER_KIND : c.count;
            end else begin
                ignored++;
            end
            pending_rsp.push_back(r);
        endfunction

        function void check_answer(t_rsp got);
            t_rsp exp_r;
            checked++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: result with no command pending: found=%0d slot=%0d gen=%0d handle=%h bumped=%0d",
                             $realtime, got.found, got.slot_out, got.generation, got.handle,
                             got.bumped);
                return;
            end
            exp_r = pending_rsp.pop_front();
            if (got.found !== exp_r.found || got.slot_out !== exp_r.slot_out ||
                got.generation !== exp_r.generation || got.handle !== exp_r.handle ||
                got.bumped !== exp_r.bumped) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("%0t: result %0d differs", $realtime, checked);
                    $display("  expected found=%0d slot=%0d gen=%0d handle=%h bumped=%0d",
                             exp_r.found, exp_r.slot_out, exp_r.generation, exp_r.handle,
                             exp_r.bumped);
                    $display("  actual   found=%0d slot=%0d gen=%0d handle=%h bumped=%0d",
                             got.found, got.slot_out, got.generation, got.handle, got.bumped);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ght_cmd_if cmd_ch ();
    ght_rsp_if rsp_ch ();

    generational_handle_table u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    slot_map_scoreboard sb = new();

    int unsigned items_sent    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left     = 0;
    bit          wrapped_run   = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial begin
        #8_000_000;
        $display("timeout with %0d results outstanding", sb.pending_rsp.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls plus a long hold-off when requested.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        t_rsp got;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                got.found      = rsp_ch.found;
                got.slot_out   = rsp_ch.slot_out;
                got.generation = rsp_ch.generation;
                got.handle     = rsp_ch.handle;
                got.bumped     = rsp_ch.bumped;
                sb.check_answer(got);
            end
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Never make live a slot that has not been written yet.
    function automatic logic [NCNT_W-1:0] legal_count(int unsigned k);
        int unsigned p;
        p = sb.first_unwritten(k);
        if (p == SLOTS_PER_KIND) begin
            if ($urandom_range(0, 1))
                return NCNT_W'($urandom_range(SLOTS_PER_KIND, (1 << NCNT_W) - 1));
            return NCNT_W'($urandom_range(0, SLOTS_PER_KIND));
        end
        if ($urandom_range(0, 9) < 7) return NCNT_W'(p);
        return NCNT_W'($urandom_range(0, p));
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [KIND_W-1:0] kind,
                             logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key,
                             logic [NCNT_W-1:0] cnt);
        t_cmd_item c;
        c = '{command: cmd, kind: kind, slot: slot, key: key, count: cnt};
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= c.command;
        cmd_ch.kind       <= c.kind;
        cmd_ch.slot_index <= c.slot;
        cmd_ch.key_id     <= c.key;
        cmd_ch.new_count  <= c.count;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        sb.note_command(c);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic run_random(int unsigned stop_at);
        int unsigned      k, s, n, j, sel, lv;
        logic [KEY_W-1:0] key_a, key_b;
        while (items_sent < stop_at) begin
            sel = $urandom_range(0, 99);
            if (!wrapped_run && items_sent >= 400) sel = 100;
            k  = $urandom_range(0, KIND_COUNT - 1);
            lv = sb.live[k];
            if (sel < 25) begin
                // grow the written prefix of a kind, then make part of it live
                if (sb.first_unwritten(FULL_KIND) < SLOTS_PER_KIND && $urandom_range(0, 1))
                    k = FULL_KIND;
                s = sb.first_unwritten(k);
                n = $urandom_range(4, 40);
                if (n > SLOTS_PER_KIND - s) n = SLOTS_PER_KIND - s;
                for (j = 0; j < n; j++) begin
                    if (s + j > 0 && $urandom_range(0, 4) == 0)
                        key_a = sb.id_mem[k][$urandom_range(0, s + j - 1)];
                    else
                        key_a = rand_key();
                    send_item(CMD_WRITE, KIND_W'(k), SLOT_W'(s + j), key_a, NCNT_W'($urandom));
                end
                send_item(CMD_COMMIT, KIND_W'(k), SLOT_W'($urandom), rand_key(), legal_count(k));
            end else if (sel < 60) begin
                n = $urandom_range(1, 6);
                for (j = 0; j < n; j++) begin
                    s = $urandom_range(0, SLOTS_PER_KIND - 1);
                    if (lv > 0 && $urandom_range(0, 9) < 6)
                        key_a = sb.id_mem[k][$urandom_range(0, lv - 1)];
                    else if (s >= lv && sb.written[k][s])
                        key_a = sb.id_mem[k][s];
                    else
                        key_a = rand_key();
                    send_item(CMD_FIND, KIND_W'(k), SLOT_W'($urandom), key_a, NCNT_W'($urandom));
                end
            end else if (sel < 80 && lv > 0) begin
                n = $urandom_range(1, 8);
                for (j = 0; j < n; j++) begin
                    s = $urandom_range(0, lv - 1);
                    case ($urandom_range(0, 2))
                        0:       key_a = sb.id_mem[k][s];
                        1:       key_a = rand_key();
                        default: key_a = sb.id_mem[k][$urandom_range(0, lv - 1)];
                    endcase
                    send_item(CMD_WRITE, KIND_W'(k), SLOT_W'(s), key_a, NCNT_W'($urandom));
                end
            end else if (sel < 88) begin
                send_item(CMD_COMMIT, KIND_W'(k), SLOT_W'($urandom), rand_key(), legal_count(k));
            end else if (sel < 100) begin
                case ($urandom_range(0, 2))
                    0: send_item(CMD_W'($urandom_range(0, 3)), KIND_NONE, SLOT_W'($urandom),
                                 rand_key(), NCNT_W'($urandom));
                    1: send_item(CMD_UNUSED, KIND_W'($urandom), SLOT_W'($urandom),
                                 rand_key(), NCNT_W'($urandom));
                    default: begin
                        if (lv < SLOTS_PER_KIND)
                            send_item(CMD_WRITE, KIND_W'(k),
                                      SLOT_W'($urandom_range(lv, SLOTS_PER_KIND - 1)),
                                      rand_key(), NCNT_W'($urandom));
                        else
                            send_item(CMD_FIND, KIND_W'(k), SLOT_W'($urandom), rand_key(),
                                      NCNT_W'($urandom));
                    end
                endcase
            end else begin
                // toggle one live slot between two ids until its generation wraps
                wrapped_run = 1;
                if (sb.live[WRAP_KIND] == 0)
                    send_item(CMD_COMMIT, KIND_W'(WRAP_KIND), '0, '0, NCNT_W'(1));
                key_a = rand_key();
                key_b = ~key_a;
                for (j = 0; j < WRAP_WRITES; j++)
                    send_item(CMD_WRITE, KIND_W'(WRAP_KIND), '0, j[0] ? key_b : key_a,
                              NCNT_W'($urandom));
                send_item(CMD_FIND, KIND_W'(WRAP_KIND), '0, key_b, '0);
            end
        end
    endtask

    initial begin
        int unsigned base;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = CMD_FIND;
        cmd_ch.kind       = '0;
        cmd_ch.slot_index = '0;
        cmd_ch.key_id     = '0;
        cmd_ch.new_count  = '0;
        rst_n             = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 59;

        // empty kind, first ids, live lookups
        send_item(CMD_FIND,   3'd0, 8'd0, '0, '0);
        send_item(CMD_WRITE,  3'd0, 8'd0, KEY_ONES, '0);
        send_item(CMD_WRITE,  3'd0, 8'd1, '0, '1);
        send_item(CMD_COMMIT, 3'd0, 8'd0, '0, 9'd2);
        send_item(CMD_FIND,   3'd0, 8'd0, KEY_ONES, '0);
        send_item(CMD_FIND,   3'd0, 8'd0, '0, '0);
        // same id keeps the generation, a new id bumps it
        send_item(CMD_WRITE,  3'd0, 8'd1, '0, '0);
        send_item(CMD_WRITE,  3'd0, 8'd1, KEY_MSB, '0);
        send_item(CMD_FIND,   3'd0, 8'd0, KEY_MSB, '0);
        // duplicate id: the lower slot wins
        send_item(CMD_WRITE,  3'd0, 8'd0, KEY_MSB, '0);
        send_item(CMD_FIND,   3'd0, 8'd0, KEY_MSB, '0);
        send_item(CMD_FIND,   3'd0, 8'd0, rand_key(), '0);
        // kind out of range and the unused command code
        send_item(CMD_FIND,   KIND_NONE, 8'd0, KEY_MSB, '0);
        send_item(CMD_WRITE,  KIND_NONE, 8'd255, KEY_ONES, '1);
        send_item(CMD_COMMIT, KIND_NONE, 8'd255, KEY_ONES, '1);
        send_item(CMD_UNUSED, 3'd0, 8'd1, KEY_MSB, 9'd2);
        // write above the live count, then hide and restore live slots
        send_item(CMD_WRITE,  3'd6, 8'd255, rand_key(), '0);
        send_item(CMD_COMMIT, 3'd0, 8'd0, '0, 9'd0);
        send_item(CMD_FIND,   3'd0, 8'd0, KEY_MSB, '0);
        send_item(CMD_COMMIT, 3'd0, 8'd0, '0, 9'd2);
        send_item(CMD_COMMIT, 3'd1, 8'd0, '0, 9'd0);
        send_item(CMD_FIND,   3'd6, 8'd0, rand_key(), '0);
        drain_results();

        base = items_sent;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin send_idle_pct = 14; recv_idle_pct = 59; end
                1: begin send_idle_pct = 59; recv_idle_pct = 14; hold_left = HOLD_CYCLES; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            run_random(base + (TOTAL_ITEMS - base) * (p + 1) / 3);
            drain_results();
        end

        repeat (SETTLE) @(posedge clk);
        $display("covered %0d finds (%0d hits), %0d writes (%0d bumps, %0d wraps), %0d commits",
                 sb.finds, sb.hits, sb.writes, sb.bumps, sb.wraps, sb.commits);
        $display("plus %0d ignored items; %0d results checked, %0d mismatches",
                 sb.ignored, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

@@ generational_handle_table.f @@
sv/ght_pkg.sv
sv/ght_if.sv
sv/ght_out_reg.sv
sv/generational_handle_table.sv
verif/generational_handle_table_tb.sv
